// ===== hdl/gif_lzw_decoder_core_macros.svh =====
// assertion helpers for the lzw decoder core
`ifndef GIF_LZW_DECODER_CORE_MACROS_SVH
`define GIF_LZW_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define GLD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GLD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/gld_pkg.sv =====
package gld_pkg;
   localparam int DICT_ENTRIES  = 4096;
   localparam int MAX_CODE_BITS = 12;
   localparam int IDX_W         = $clog2(DICT_ENTRIES);
   localparam logic [12:0] NO_CODE = 13'd4098;

   typedef enum logic {OP_PUSH = 1'b0, OP_PULL = 1'b1} op_type;

   typedef enum logic [2:0] {
      ST_PIXEL = 3'd0, ST_TAKEN = 3'd1, ST_NEED = 3'd2, ST_FULL = 3'd3,
      ST_END = 3'd4, ST_BAD = 3'd5, ST_COUNT = 3'd6
   } status_type;

   typedef enum logic {REG_MIN_SIZE = 1'b0, REG_PIXEL_TOTAL = 1'b1} reg_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic        busy;
      logic [3:0]  code_width;
      logic [12:0] next_code;
      logic [12:0] stack_ptr;
   } mon_type;

   function automatic logic [3:0] eff_min(input logic [3:0] v);
      if (v < 4'd2) return 4'd2;
      if (v > 4'd8) return 4'd8;
      return v;
   endfunction
endpackage

// ===== hdl/gld_if.sv =====
interface gld_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;
   modport source(output valid, output operation, output data_byte, input ready);
   modport sink(input valid, input operation, input data_byte, output ready);
endinterface

interface gld_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] pixel;
   logic       last;
   modport source(output valid, output status, output pixel, output last, input ready);
   modport sink(input valid, input status, input pixel, input last, output ready);
endinterface

// ===== hdl/gif_lzw_decoder_core.sv =====
// push transfer: the engine decides, then the result transfer
// pull from the pixel stack: take, registered stack read, result transfer
// pull that decodes: take, code reads (clear codes included), chain steps, finish,
// then the result transfer; the next item is taken once the result has gone
// synchronous active-high reset; no clearing pass, only entries below next_code are read
module gif_lzw_decoder_core (
   input  logic        clock,
   input  logic        reset,
   gld_req_if.sink     req_if,
   gld_rsp_if.source   rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import gld_pkg::*;
   `include "gif_lzw_decoder_core_macros.svh"

   logic       q_valid, q_take;
   item_type   q_item;
   logic       cfg_wr, we_min, we_total;
   logic [3:0] min_size;
   logic [23:0] total;
   mon_type    mon;
   logic [12:0] restart_code;

   // front: queue input transfers
   gld_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_ready (req_if.ready),
      .in_op    (req_if.operation),
      .in_byte  (req_if.data_byte),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_take   (q_take)
   );

   // register writes complete in the access phase
   assign pready   = 1'b1;
   assign cfg_wr   = psel && penable && pwrite;
   assign we_min   = cfg_wr && (reg_type'(paddr[2]) == REG_MIN_SIZE);
   assign we_total = cfg_wr && (reg_type'(paddr[2]) == REG_PIXEL_TOTAL);
   assign prdata   = (reg_type'(paddr[2]) == REG_MIN_SIZE) ? {28'd0, min_size}
                                                           : {8'd0, total};

   // back: bit unpacking, code decode, prefix walk, pixel stack
   gld_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item       (q_item),
      .item_take  (q_take),
      .we_min     (we_min),
      .we_total   (we_total),
      .wdata      (pwdata),
      .min_size   (min_size),
      .total      (total),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .out_status (rsp_if.status),
      .out_pixel  (rsp_if.pixel),
      .out_last   (rsp_if.last),
      .mon        (mon)
   );

   // first free code after a dictionary restart
   assign restart_code = (13'd1 << eff_min(min_size)) + 13'd2;

   `GLD_ASSERT_NOW(a_width_cap, 1'b1, mon.code_width <= 4'(MAX_CODE_BITS), "code width too large")
   `GLD_ASSERT_NOW(a_stack_cap, 1'b1, mon.stack_ptr <= 13'(DICT_ENTRIES), "stack overflow")
   `GLD_ASSERT_NXT(a_min_restart, we_min, mon.next_code == restart_code, "restart")
   `GLD_ASSERT_NOW(a_take_idle, q_take, !mon.busy && !rsp_if.valid, "item taken while busy")
endmodule

// ===== hdl/gld_front.sv =====
module gld_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_op,
   input  logic [7:0]        in_byte,
   output logic              q_valid,
   output gld_pkg::item_type q_item,
   input  logic              q_take
);
   import gld_pkg::*;

   item_type   slot_ff [2];
   logic       rd_ptr_ff, wr_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_take && q_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{operation: op_type'(in_op), data_byte: in_byte};
      end
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ===== hdl/gld_engine.sv =====
module gld_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  gld_pkg::item_type item,
   output logic              item_take,
   input  logic              we_min,
   input  logic              we_total,
   input  logic [31:0]       wdata,
   output logic [3:0]        min_size,
   output logic [23:0]       total,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [2:0]        out_status,
   output logic [7:0]        out_pixel,
   output logic              out_last,
   output gld_pkg::mon_type  mon
);
   import gld_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_POP, S_FETCH, S_WALK} state_type;

   state_type   state_ff, state_in;
   logic [3:0]  min_ff, min_in;
   logic [23:0] total_ff, total_in;
   logic [12:0] sp_ff, sp_in;
   logic [31:0] buf_ff, buf_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [3:0]  cw_ff, cw_in;
   logic [12:0] nc_ff, nc_in;
   logic [12:0] prev_ff, prev_in;
   logic [7:0]  rem_ff, rem_in;
   logic [23:0] emitted_ff, emitted_in;
   logic        done_ff, done_in;
   logic        ended_ff, ended_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] code_ff, code_in;
   logic        kw_ff, kw_in;
   logic        ov_ff, ov_in;
   status_type  st_ff, st_in;
   logic [7:0]  px_ff, px_in;
   logic        last_ff, last_in;

   logic [IDX_W-1:0] pfx_mem [DICT_ENTRIES];
   logic [7:0]       sfx_mem [DICT_ENTRIES];
   logic [7:0]       stk_mem [DICT_ENTRIES];
   logic [IDX_W-1:0] pfx_rd_ff;
   logic [7:0]       sfx_rd_ff, stk_rd_ff;

   logic             tbl_we, stk_we;
   logic [IDX_W-1:0] tbl_raddr, tbl_waddr, stk_raddr, stk_waddr;
   logic [IDX_W-1:0] tbl_wpfx;
   logic [7:0]       tbl_wsfx, stk_wdata;

   logic [3:0]  emin, wmin;
   logic [12:0] clr;
   logic [IDX_W-1:0] mask, c;
   logic [12:0] c13;
   logic        do_fin, do_emit, do_resp;
   logic [IDX_W-1:0] fin_code;
   logic [7:0]  fin_root, emit_px;
   status_type  resp_st;
   logic [13:0] limit;

   always_comb begin
      state_in = state_ff; min_in = min_ff; total_in = total_ff; sp_in = sp_ff;
      buf_in = buf_ff; cnt_in = cnt_ff; cw_in = cw_ff; nc_in = nc_ff; prev_in = prev_ff;
      rem_in = rem_ff; emitted_in = emitted_ff; done_in = done_ff; ended_in = ended_ff;
      cur_in = cur_ff; code_in = code_ff; kw_in = kw_ff; ov_in = ov_ff; st_in = st_ff;
      px_in = px_ff; last_in = last_ff;
      item_take = 1'b0; tbl_we = 1'b0; stk_we = 1'b0;
      tbl_raddr = cur_ff; tbl_waddr = nc_ff[IDX_W-1:0]; tbl_wpfx = prev_ff[IDX_W-1:0];
      tbl_wsfx = 8'd0; stk_raddr = sp_ff[IDX_W-1:0]; stk_waddr = sp_ff[IDX_W-1:0];
      stk_wdata = sfx_rd_ff;
      do_fin = 1'b0; do_emit = 1'b0; do_resp = 1'b0; resp_st = ST_TAKEN;
      fin_code = code_ff; fin_root = 8'd0; emit_px = stk_rd_ff;
      emin = eff_min(min_ff);
      clr  = 13'd1 << emin;
      mask = ~({IDX_W{1'b1}} << cw_ff);
      c    = buf_ff[IDX_W-1:0] & mask;
      c13  = {1'b0, c};
      wmin = eff_min(wdata[3:0]);
      limit = 14'd1 << cw_ff;

      if (out_ready && ov_ff) ov_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (item_valid && !ov_ff) begin
               item_take = 1'b1;
               if (item.operation == OP_PULL) begin
                  if (done_ff || emitted_ff >= total_ff) begin
                     done_in = 1'b1; do_resp = 1'b1; resp_st = ST_END;
                  end else if (sp_ff != 13'd0) begin
                     sp_in = sp_ff - 13'd1;
                     stk_raddr = sp_in[IDX_W-1:0];
                     state_in = S_POP;
                  end else begin
                     state_in = S_FETCH;
                  end
               end else begin
                  do_resp = 1'b1;
                  if (ended_ff) begin
                     resp_st = ST_END;
                  end else if (rem_ff == 8'd0) begin
                     if (item.data_byte == 8'd0) ended_in = 1'b1;
                     else rem_in = item.data_byte;
                  end else if (cnt_ff > 6'd24) begin
                     resp_st = ST_FULL;
                  end else begin
                     buf_in = buf_ff | ({24'd0, item.data_byte} << cnt_ff);
                     cnt_in = cnt_ff + 6'd8;
                     rem_in = rem_ff - 8'd1;
                  end
               end
            end
         end
         S_POP: begin
            do_emit = 1'b1; emit_px = stk_rd_ff;
         end
         S_FETCH: begin
            if (cnt_ff < {2'd0, cw_ff}) begin
               do_resp = 1'b1;
               if (ended_ff) begin
                  done_in = 1'b1; resp_st = ST_COUNT;
               end else begin
                  resp_st = ST_NEED;
               end
            end else begin
               buf_in = buf_ff >> cw_ff;
               cnt_in = cnt_ff - {2'd0, cw_ff};
               code_in = c;
               if (c13 == clr) begin
                  cw_in = emin + 4'd1; nc_in = clr + 13'd2; prev_in = NO_CODE;
               end else if (c13 == clr + 13'd1) begin
                  done_in = 1'b1; do_resp = 1'b1; resp_st = ST_COUNT;
               end else if (c13 < clr) begin
                  do_fin = 1'b1; fin_code = c; fin_root = c[7:0];
               end else if (c13 < nc_ff) begin
                  cur_in = c; tbl_raddr = c; kw_in = 1'b0; state_in = S_WALK;
               end else if (c13 == nc_ff && prev_ff != NO_CODE &&
                            nc_ff < 13'(DICT_ENTRIES)) begin
                  sp_in = 13'd1; kw_in = 1'b1;
                  cur_in = prev_ff[IDX_W-1:0]; tbl_raddr = prev_ff[IDX_W-1:0];
                  state_in = S_WALK;
               end else begin
                  do_resp = 1'b1; resp_st = ST_BAD;
               end
            end
         end
         S_WALK: begin
            if ({1'b0, cur_ff} >= clr + 13'd2) begin
               if (sp_ff < 13'(DICT_ENTRIES)) begin
                  stk_we = 1'b1; stk_wdata = sfx_rd_ff;
                  sp_in = sp_ff + 13'd1;
               end
               cur_in = pfx_rd_ff; tbl_raddr = pfx_rd_ff;
            end else if ({1'b0, cur_ff} >= clr) begin
               sp_in = 13'd0; do_resp = 1'b1; resp_st = ST_BAD;
            end else begin
               if (kw_ff) begin
                  stk_we = 1'b1; stk_waddr = '0; stk_wdata = cur_ff[7:0];
               end
               do_fin = 1'b1; fin_code = code_ff; fin_root = cur_ff[7:0];
            end
         end
         default: state_in = S_IDLE;
      endcase

      // dictionary grows by one entry per decoded code that follows another, until it is full
      if (do_fin) begin
         if (prev_ff != NO_CODE && nc_ff < 13'(DICT_ENTRIES)) begin
            tbl_we = 1'b1; tbl_wsfx = fin_root;
            nc_in = nc_ff + 13'd1;
            if ({1'b0, nc_in} >= limit && cw_ff < 4'(MAX_CODE_BITS)) cw_in = cw_ff + 4'd1;
         end
         prev_in = {1'b0, fin_code};
         do_emit = 1'b1; emit_px = fin_root;
      end
      if (do_emit) begin
         emitted_in = emitted_ff + 24'd1;
         ov_in = 1'b1; st_in = ST_PIXEL; px_in = emit_px;
         last_in = (emitted_in == total_ff);
         if (last_in) done_in = 1'b1;
         state_in = S_IDLE;
      end
      if (do_resp) begin
         ov_in = 1'b1; st_in = resp_st; px_in = 8'd0; last_in = 1'b0;
         state_in = S_IDLE;
      end

      if (we_min) begin
         min_in = wdata[3:0];
         cw_in = wmin + 4'd1; nc_in = (13'd1 << wmin) + 13'd2; prev_in = NO_CODE;
      end
      if (we_total) total_in = wdata[23:0];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         pfx_mem[tbl_waddr] <= tbl_wpfx;
         sfx_mem[tbl_waddr] <= tbl_wsfx;
      end
      pfx_rd_ff <= pfx_mem[tbl_raddr];
      sfx_rd_ff <= sfx_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
      stk_rd_ff <= stk_mem[stk_raddr];
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in; code_ff <= code_in; px_ff <= px_in;
      if (reset) begin
         state_ff <= S_IDLE; min_ff <= 4'd8; total_ff <= '0; sp_ff <= '0;
         buf_ff <= '0; cnt_ff <= '0; cw_ff <= 4'd9; nc_ff <= 13'd258;
         prev_ff <= NO_CODE; rem_ff <= '0; emitted_ff <= '0; done_ff <= 1'b0;
         ended_ff <= 1'b0; kw_ff <= 1'b0; ov_ff <= 1'b0; st_ff <= ST_TAKEN;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in; min_ff <= min_in; total_ff <= total_in; sp_ff <= sp_in;
         buf_ff <= buf_in; cnt_ff <= cnt_in; cw_ff <= cw_in; nc_ff <= nc_in;
         prev_ff <= prev_in; rem_ff <= rem_in; emitted_ff <= emitted_in;
         done_ff <= done_in; ended_ff <= ended_in; kw_ff <= kw_in; ov_ff <= ov_in;
         st_ff <= st_in; last_ff <= last_in;
      end
   end

   assign min_size   = min_ff;
   assign total      = total_ff;
   assign out_valid  = ov_ff;
   assign out_status = st_ff;
   assign out_pixel  = px_ff;
   assign out_last   = last_ff;
   assign mon = '{busy: (state_ff != S_IDLE), code_width: cw_ff,
                  next_code: nc_ff, stack_ptr: sp_ff};
endmodule

// ===== verif/gif_lzw_decoder_core_tb.sv =====
`timescale 1ns / 100ps

module gif_lzw_decoder_core_tb;
   import gld_pkg::*;

   typedef struct packed {
      status_type st;
      logic [7:0] px;
      logic       lst;
   } pixel_result_type;

   // one row of the directed stream
   typedef struct {
      op_type           op;
      logic [7:0]       data;
      bit               known;
      pixel_result_type want;
   } stim_row_type;

   localparam int TABLE_SIZE = 4096;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // register port
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   gld_req_if req_bus();
   gld_rsp_if rsp_bus();

   gif_lzw_decoder_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_PUSH;
      req_bus.data_byte = '0;
      rsp_bus.ready     = 1'b0;
   end

   // ---------------------------------------------------------------
   // decoder shadow: dictionary, pixel stack, bit buffer and counters
   // ---------------------------------------------------------------
   logic [3:0]  dec_min_reg;
   logic [23:0] dec_total;
   logic [12:0] dec_prefix [TABLE_SIZE];
   logic [7:0]  dec_suffix [TABLE_SIZE];
   logic [7:0]  dec_stack  [TABLE_SIZE];
   int          dec_sp, dec_bits, dec_width, dec_next, dec_prev, dec_sub_left;
   logic [31:0] dec_buf;
   int          dec_emitted;
   bit          dec_done, dec_stream_end;

   function automatic int clamp_min(input logic [3:0] v);
      if (v < 2) return 2;
      if (v > 8) return 8;
      return int'(v);
   endfunction

   function automatic void dict_restart();
      for (int i = 0; i < TABLE_SIZE; i++) dec_prefix[i] = NO_CODE;
      dec_width = clamp_min(dec_min_reg) + 1;
      dec_next  = (1 << clamp_min(dec_min_reg)) + 2;
      dec_prev  = NO_CODE;
   endfunction

   function automatic void stack_push(input logic [7:0] v);
      if (dec_sp < TABLE_SIZE) begin
         dec_stack[dec_sp] = v;
         dec_sp++;
      end
   endfunction

   // push the suffixes of a chain, return its root symbol or -1 if broken
   function automatic int chain_walk(input int code, input int clr);
      int cur, n;
      cur = code;
      n = 0;
      while (cur >= clr + 2 && cur < DICT_ENTRIES && n < DICT_ENTRIES) begin
         stack_push(dec_suffix[cur % TABLE_SIZE]);
         cur = dec_prefix[cur % TABLE_SIZE];
         n++;
      end
      if (cur >= clr) return -1;
      return cur;
   endfunction

   function automatic pixel_result_type pull_pixel();
      pixel_result_type r;
      int clr, c, root, slot;
      logic [7:0] pix;
      r = '{st: ST_PIXEL, px: 8'd0, lst: 1'b0};
      clr = 1 << clamp_min(dec_min_reg);
      if (dec_done || dec_emitted >= dec_total) begin
         dec_done = 1'b1;
         r.st = ST_END;
         return r;
      end
      if (dec_sp > 0) begin
         dec_sp--;
         pix = dec_stack[dec_sp % TABLE_SIZE];
      end else begin
         forever begin
            if (dec_bits < dec_width) begin
               if (dec_stream_end) begin
                  dec_done = 1'b1;
                  r.st = ST_COUNT;
               end else begin
                  r.st = ST_NEED;
               end
               return r;
            end
            c = int'(dec_buf & ((32'd1 << dec_width) - 1));
            dec_buf  = dec_buf >> dec_width;
            dec_bits = dec_bits - dec_width;
            if (c == clr) begin
               dict_restart();
               continue;
            end
            if (c == clr + 1) begin
               dec_done = 1'b1;
               r.st = ST_COUNT;
               return r;
            end
            if (c < clr) begin
               root = c;
               pix = c[7:0];
            end else if (c < dec_next) begin
               root = chain_walk(c, clr);
               if (root < 0) begin
                  dec_sp = 0;
                  r.st = ST_BAD;
                  return r;
               end
               stack_push(root[7:0]);
               dec_sp--;
               pix = dec_stack[dec_sp % TABLE_SIZE];
            end else if (c == dec_next && dec_prev != NO_CODE && dec_next < DICT_ENTRIES) begin
               // code not yet in the table: previous string plus its own first symbol
               slot = dec_sp;
               stack_push(8'd0);
               root = chain_walk(dec_prev, clr);
               if (root < 0) begin
                  dec_sp = 0;
                  r.st = ST_BAD;
                  return r;
               end
               dec_stack[slot % TABLE_SIZE] = root[7:0];
               stack_push(root[7:0]);
               dec_sp--;
               pix = dec_stack[dec_sp % TABLE_SIZE];
            end else begin
               r.st = ST_BAD;
               return r;
            end
            if (dec_prev != NO_CODE && dec_next < DICT_ENTRIES) begin
               dec_prefix[dec_next] = dec_prev[12:0];
               dec_suffix[dec_next] = root[7:0];
               dec_next++;
               if (dec_next >= (1 << dec_width) && dec_width < MAX_CODE_BITS) dec_width++;
            end
            dec_prev = c;
            break;
         end
      end
      dec_emitted++;
      r.px = pix;
      if (dec_emitted == dec_total) begin
         r.lst = 1'b1;
         dec_done = 1'b1;
      end
      return r;
   endfunction

   function automatic pixel_result_type push_byte(input logic [7:0] b);
      pixel_result_type r;
      r = '{st: ST_TAKEN, px: 8'd0, lst: 1'b0};
      if (dec_stream_end) begin
         r.st = ST_END;
      end else if (dec_sub_left == 0) begin
         if (b == 8'd0) dec_stream_end = 1'b1;
         else dec_sub_left = b;
      end else if (dec_bits > 24) begin
         r.st = ST_FULL;
      end else begin
         dec_buf = dec_buf | (32'(b) << dec_bits);
         dec_bits += 8;
         dec_sub_left--;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // checking of result transfers
   // ---------------------------------------------------------------
   pixel_result_type pending_pixels[$];
   int errors = 0;
   int n_pixel = 0, n_bad = 0, n_full = 0, n_need = 0, n_end = 0;
   bit hold_req = 1'b0;
   int hold_left = 0;
   int stall_mode = 0;
   int cycle_count = 0;

   always @(posedge clock) begin
      pixel_result_type w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pixels.size() == 0) begin
            $error("result transfer with nothing expected: status %0d", rsp_bus.status);
            errors++;
         end else begin
            w = pending_pixels.pop_front();
            if (rsp_bus.status !== w.st) begin
               $error("status: expected %0d, got %0d", w.st, rsp_bus.status);
               errors++;
            end
            if (rsp_bus.pixel !== w.px) begin
               $error("pixel: expected %0d, got %0d", w.px, rsp_bus.pixel);
               errors++;
            end
            if (rsp_bus.last !== w.lst) begin
               $error("last: expected %0d, got %0d", w.lst, rsp_bus.last);
               errors++;
            end
            case (w.st)
               ST_PIXEL: n_pixel++;
               ST_BAD:   n_bad++;
               ST_FULL:  n_full++;
               ST_NEED:  n_need++;
               ST_END:   n_end++;
               default: ;
            endcase
         end
      end
      // receiver stall pattern, with one long hold-off
      cycle_count++;
      if (cycle_count % 160 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_bus.ready <= $urandom_range(0, 1);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------
   int burst_left = 0;
   int items_sent = 0;

   task automatic send_item(input op_type op, input logic [7:0] b, input bit known,
                            input pixel_result_type want, output status_type got);
      pixel_result_type r;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      // transfer accepted at this edge
      r = (op == OP_PULL) ? pull_pixel() : push_byte(b);
      pending_pixels.push_back(known ? want : r);
      got = r.st;
      items_sent++;
   endtask

   task automatic pull();
      status_type s;
      send_item(OP_PULL, 8'($urandom), 1'b0, '0, s);
   endtask

   task automatic push_raw(input logic [7:0] b, output status_type s);
      send_item(OP_PUSH, b, 1'b0, '0, s);
   endtask

   // wait until every result is in, then let the engine go quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input reg_type idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_MIN_SIZE) begin
         dec_min_reg = val[3:0];
         dict_restart();
      end else begin
         dec_total = val[23:0];
      end
   endtask

   // ---------------------------------------------------------------
   // code stream builder: tracks the dictionary size the decoder will have
   // ---------------------------------------------------------------
   int          enc_clear, enc_width, enc_next;
   bit          enc_prev;
   logic [63:0] enc_acc;
   int          enc_acc_bits;
   int          frame_left = 0;

   function automatic void enc_restart();
      enc_clear = 1 << clamp_min(dec_min_reg);
      enc_width = clamp_min(dec_min_reg) + 1;
      enc_next  = enc_clear + 2;
      enc_prev  = 1'b0;
   endfunction

   function automatic void enc_note(input int c);
      if (c == enc_clear) begin
         enc_restart();
      end else if (c < enc_next || (c == enc_next && enc_prev && enc_next < DICT_ENTRIES)) begin
         if (enc_prev && enc_next < DICT_ENTRIES) begin
            enc_next++;
            if (enc_next >= (1 << enc_width) && enc_width < MAX_CODE_BITS) enc_width++;
         end
         enc_prev = 1'b1;
      end
   endfunction

   function automatic void enc_pack(input int c);
      enc_acc = enc_acc | (64'(c) << enc_acc_bits);
      enc_acc_bits += enc_width;
      enc_note(c);
   endfunction

   function automatic int pick_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return enc_clear;
      if (r < 6 && enc_next + 1 < (1 << enc_width))
         return $urandom_range(enc_next + 1, (1 << enc_width) - 1);
      if (r < 14 && enc_prev && enc_next < DICT_ENTRIES) return enc_next;
      if (r < 60 && enc_next > enc_clear + 2) return $urandom_range(enc_clear + 2, enc_next - 1);
      return $urandom_range(0, enc_clear - 1);
   endfunction

   // one data byte inside the sub-block framing; a refused byte is retried
   task automatic push_data(input logic [7:0] b);
      status_type s;
      int len;
      if (frame_left == 0) begin
         len = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(1, 16);
         push_raw(8'(len), s);
         frame_left = len;
      end
      forever begin
         push_raw(b, s);
         if (s != ST_FULL) break;
         pull();
      end
      frame_left--;
   endtask

   task automatic flush_bytes(input bit pad);
      if (pad && (enc_acc_bits % 8) != 0) enc_acc_bits += 8 - (enc_acc_bits % 8);
      while (enc_acc_bits >= 8) begin
         push_data(enc_acc[7:0]);
         enc_acc = enc_acc >> 8;
         enc_acc_bits -= 8;
      end
   endtask

   // pull until the decoder has neither stacked pixels nor a whole code
   task automatic drain_codes();
      while (dec_sp > 0 || dec_bits >= dec_width) pull();
   endtask

   // left-over zero padding in the decoder is read as code 0: extend it to a code
   // boundary so that the following codes line up; returns the number of such codes
   function automatic int realign();
      int q, k;
      q = dec_bits;
      k = 0;
      while (q > 0) begin
         if (q >= enc_width) begin
            q -= enc_width;
         end else begin
            enc_acc_bits += enc_width - q;
            q = 0;
         end
         enc_note(0);
         k++;
      end
      return k;
   endfunction

   // ---------------------------------------------------------------
   // directed stream at minimum size 8, 9-bit codes:
   // clear, 0, 255, 259 (not yet in table), 300 (bad), three pad bits;
   // the last two bytes go in once two pulls have made room in the buffer
   // ---------------------------------------------------------------
   localparam pixel_result_type R_TAKEN = '{st: ST_TAKEN, px: 8'd0, lst: 1'b0};

   stim_row_type directed [] = '{
      '{OP_PUSH, 8'h06, 1'b1, R_TAKEN},
      '{OP_PUSH, 8'h00, 1'b1, R_TAKEN},
      '{OP_PUSH, 8'h01, 1'b1, R_TAKEN},
      '{OP_PUSH, 8'hFC, 1'b1, R_TAKEN},
      '{OP_PUSH, 8'h1B, 1'b1, R_TAKEN},
      '{OP_PULL, 8'hFF, 1'b1, '{st: ST_PIXEL, px: 8'd0, lst: 1'b0}},
      '{OP_PULL, 8'h00, 1'b1, '{st: ST_PIXEL, px: 8'd255, lst: 1'b0}},
      '{OP_PUSH, 8'hC8, 1'b1, R_TAKEN},
      '{OP_PUSH, 8'h12, 1'b1, R_TAKEN},
      '{OP_PULL, 8'h00, 1'b0, '0},
      '{OP_PULL, 8'h00, 1'b0, '0},
      '{OP_PULL, 8'h00, 1'b1, '{st: ST_BAD, px: 8'd0, lst: 1'b0}},
      '{OP_PULL, 8'h00, 1'b1, '{st: ST_NEED, px: 8'd0, lst: 1'b0}},
      '{OP_PULL, 8'hAA, 1'b1, '{st: ST_NEED, px: 8'd0, lst: 1'b0}}
   };

   int min_sizes [8] = '{2, 8, 0, 15, 5, 3, 7, 4};

   initial begin
      status_type s;
      int ph, n, k, nbytes;
      dec_min_reg    = 4'd8;
      dec_total      = '0;
      dec_sp         = 0;
      dec_buf        = '0;
      dec_bits       = 0;
      dec_sub_left   = 0;
      dec_emitted    = 0;
      dec_done       = 1'b0;
      dec_stream_end = 1'b0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         dec_suffix[i] = '0;
         dec_stack[i]  = '0;
      end
      dict_restart();
      enc_acc      = '0;
      enc_acc_bits = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a pull with pixel_total at zero would end the image, so set it first
      csr_write(REG_PIXEL_TOTAL, 32'hFF_FFFF);
      csr_write(REG_MIN_SIZE, 32'd8);

      foreach (directed[i])
         send_item(directed[i].op, directed[i].data, directed[i].known, directed[i].want, s);
      frame_left = dec_sub_left;

      // random phases, each under its own minimum code size
      ph = 0;
      while (items_sent < 720) begin
         settle();
         csr_write(REG_MIN_SIZE, 32'(min_sizes[ph % 8]));
         enc_restart();
         k = realign();
         if (ph == 2) hold_req = 1'b1;
         n = $urandom_range(20, 45);
         for (int i = 0; i < n; i++) begin
            enc_pack(pick_code());
            flush_bytes(1'b0);
            repeat ($urandom_range(0, 3)) pull();
         end
         flush_bytes(1'b1);
         drain_codes();
         ph++;
      end

      // close the open sub-block with zero bytes, read them out as code 0
      while (frame_left > 0) push_data(8'd0);
      drain_codes();
      settle();

      // last image: a few pixels up to pixel_total, then stream end
      csr_write(REG_MIN_SIZE, 32'd8);
      enc_restart();
      k = realign();
      csr_write(REG_PIXEL_TOTAL, 32'(dec_emitted + k + 1));
      enc_pack($urandom_range(0, enc_clear - 1));
      if ((enc_acc_bits % 8) != 0) enc_acc_bits += 8 - (enc_acc_bits % 8);
      nbytes = enc_acc_bits / 8;
      push_raw(8'(nbytes), s);
      frame_left = nbytes;
      flush_bytes(1'b0);
      while (!dec_done) pull();
      pull();
      push_raw(8'd0, s);
      push_raw(8'hA5, s);
      settle();
      csr_write(REG_PIXEL_TOTAL, 32'd0);
      repeat (20) @(posedge clock);

      $display("covered %0d transfers in %0d code-size phases", items_sent, ph);
      $display("pixels %0d, bad codes %0d, refused bytes %0d, need-data %0d, end %0d",
               n_pixel, n_bad, n_full, n_need, n_end);
      if (errors == 0 && pending_pixels.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // overall limit on the run
   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

endmodule
